FILE: hw/rtl/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ORHT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ORHT_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ORHT_ASSERT(lbl, clk, rst_n, prop, msg)
`define ORHT_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

FILE: hw/rtl/orht_pkg.sv
package orht_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int OWNER_COUNT   = 256;
  localparam int COORD_BITS    = 16;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = IDX_W + 1;
  localparam int SUM_W         = COORD_BITS + 2;
  localparam int OWNER_W       = 8;
  localparam int ID_W          = 32;
  localparam int OUT_IDX_W     = 8;
  localparam logic [ID_W-1:0] ID_CMP_MASK = 32'hFF_FFFF;

  typedef enum logic [2:0] {
    REQ_DEFINE  = 3'd0,
    REQ_REMOVE  = 3'd1,
    REQ_FIND_ID = 3'd2,
    REQ_FIND_PT = 3'd3,
    REQ_CLEAR   = 3'd4
  } req_kind_t;

  typedef enum logic [1:0] {
    STAT_DONE = 2'd0,
    STAT_DUP  = 2'd1,
    STAT_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_PUSH
  } state_t;

  typedef struct packed {
    logic [OWNER_W-1:0]           owner;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0]        w;
    logic [COORD_BITS-1:0]        h;
    logic [ID_W-1:0]              id;
  } entry_t;

  typedef struct packed {
    req_kind_t                    kind;
    entry_t                       ent;
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
  } req_t;

  typedef struct packed {
    logic owner_eq;
    logic dup;
    logic id_eq;
    logic pt_in;
  } match_t;

  typedef struct packed {
    status_t                status;
    logic                   found;
    logic [OUT_IDX_W-1:0]   index;
    entry_t                 ent;
  } res_t;

endpackage

FILE: hw/rtl/orht_slot_mem.sv
module orht_slot_mem (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [orht_pkg::IDX_W-1:0] wr_addr,
  input  orht_pkg::entry_t           wr_data,
  input  logic [orht_pkg::IDX_W-1:0] rd_addr,
  output orht_pkg::entry_t           rd_data
);

  orht_pkg::entry_t mem [orht_pkg::TABLE_ENTRIES];
  orht_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/orht_match.sv
module orht_match (
  input  orht_pkg::req_t   req,
  input  orht_pkg::entry_t ent,
  output orht_pkg::match_t match
);

  logic signed [orht_pkg::SUM_W-1:0] qx, qy, ex, ey, ex_end, ey_end;
  logic in_x, in_y;

  always_comb begin
    qx     = orht_pkg::SUM_W'(req.px) - orht_pkg::SUM_W'(1);
    qy     = orht_pkg::SUM_W'(req.py) - orht_pkg::SUM_W'(1);
    ex     = orht_pkg::SUM_W'(ent.x);
    ey     = orht_pkg::SUM_W'(ent.y);
    ex_end = ex + $signed({2'b00, ent.w});
    ey_end = ey + $signed({2'b00, ent.h});
    in_x   = (qx > ex) && (qx <= ex_end);
    in_y   = (qy > ey) && (qy <= ey_end);

    match.owner_eq = (ent.owner == req.ent.owner);
    match.dup      = match.owner_eq && (ent.x == req.ent.x) && (ent.y == req.ent.y) &&
                     (ent.w == req.ent.w) && (ent.h == req.ent.h);
    match.id_eq    = match.owner_eq &&
                     ((ent.id & orht_pkg::ID_CMP_MASK) == (req.ent.id & orht_pkg::ID_CMP_MASK));
    match.pt_in    = match.owner_eq && in_x && in_y;
  end

endmodule

FILE: hw/rtl/owned_rectangle_hit_table.sv
// Rectangle table of TABLE_ENTRIES slots, each with owner, edges, size and id. Every request
// walks the slots from slot 0 in order, one slot per clock through the single read port of
// the slot memory, and stops at its first decisive slot; remove and clear always walk the
// whole table. An unknown request type skips the scan and gives an all-zero result. One
// request is in work at a time; the next word is taken while the last result still waits
// on out_stall. Free/used flags sit in flip-flops cleared by reset, so no clearing pass
// follows reset.
`include "assert_macros.svh"

module owned_rectangle_hit_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_req_type,
  input  logic [7:0]  in_owner,
  input  logic signed [15:0] in_rect_x,
  input  logic signed [15:0] in_rect_y,
  input  logic [15:0] in_rect_w,
  input  logic [15:0] in_rect_h,
  input  logic [31:0] in_button_id,
  input  logic signed [15:0] in_point_x,
  input  logic signed [15:0] in_point_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_found,
  output logic [7:0]  out_entry_index,
  output logic [31:0] out_found_id,
  output logic signed [15:0] out_found_x,
  output logic signed [15:0] out_found_y,
  output logic [15:0] out_found_w,
  output logic [15:0] out_found_h
);

  localparam logic [orht_pkg::IDX_W-1:0] LAST_IDX =
    orht_pkg::IDX_W'(orht_pkg::TABLE_ENTRIES - 1);

  orht_pkg::state_t state_r, state_nxt;
  orht_pkg::req_t   req_r, req_nxt;
  orht_pkg::res_t   res_r, res_nxt;
  orht_pkg::res_t   out_r;
  logic             out_valid_r, out_valid_nxt;
  logic [orht_pkg::TABLE_ENTRIES-1:0] used_r, used_nxt;
  logic [orht_pkg::CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [orht_pkg::IDX_W-1:0] cmp_idx_r;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic             out_free, push_fire, store_fire, done, slot_used, last, req_ok;
  orht_pkg::entry_t rd_ent;
  orht_pkg::match_t match;

  orht_slot_mem u_mem (
    .clk     (clk),
    .wr_en   (store_fire),
    .wr_addr (cmp_idx_r),
    .wr_data (req_r.ent),
    .rd_addr (rd_idx_r[orht_pkg::IDX_W-1:0]),
    .rd_data (rd_ent)
  );

  orht_match u_match (
    .req   (req_r),
    .ent   (rd_ent),
    .match (match)
  );

  assign in_stall  = (state_r != orht_pkg::S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign push_fire = (state_r == orht_pkg::S_PUSH) && out_free;
  assign req_ok    = (in_req_type <= 3'(orht_pkg::REQ_CLEAR)) &&
                     (32'(in_owner) < orht_pkg::OWNER_COUNT);

  always_comb begin
    state_nxt   = state_r;
    req_nxt     = req_r;
    res_nxt     = res_r;
    used_nxt    = used_r;
    rd_idx_nxt  = rd_idx_r;
    cmp_vld_nxt = 1'b0;
    store_fire  = 1'b0;
    done        = 1'b0;
    slot_used   = used_r[cmp_idx_r];
    last        = (cmp_idx_r == LAST_IDX);
    unique case (state_r)
      orht_pkg::S_IDLE: begin
        if (in_valid) begin
          req_nxt.kind      = orht_pkg::req_kind_t'(in_req_type);
          req_nxt.ent.owner = in_owner;
          req_nxt.ent.x     = in_rect_x;
          req_nxt.ent.y     = in_rect_y;
          req_nxt.ent.w     = in_rect_w;
          req_nxt.ent.h     = in_rect_h;
          req_nxt.ent.id    = in_button_id;
          req_nxt.px        = in_point_x;
          req_nxt.py        = in_point_y;
          res_nxt           = '0;
          rd_idx_nxt        = '0;
          state_nxt         = req_ok ? orht_pkg::S_SCAN : orht_pkg::S_PUSH;
        end
      end
      orht_pkg::S_SCAN: begin
        if (!rd_idx_r[orht_pkg::IDX_W]) begin
          rd_idx_nxt  = rd_idx_r + orht_pkg::CNT_W'(1);
          cmp_vld_nxt = 1'b1;
        end
        if (cmp_vld_r) begin
          unique case (req_r.kind)
            orht_pkg::REQ_DEFINE: begin
              if (!slot_used) begin
                store_fire                = 1'b1;
                used_nxt[cmp_idx_r]       = 1'b1;
                res_nxt.status            = orht_pkg::STAT_DONE;
                res_nxt.index             = orht_pkg::OUT_IDX_W'(cmp_idx_r);
                done                      = 1'b1;
              end else if (match.dup) begin
                res_nxt.status            = orht_pkg::STAT_DUP;
                res_nxt.index             = orht_pkg::OUT_IDX_W'(cmp_idx_r);
                done                      = 1'b1;
              end else if (last) begin
                res_nxt.status            = orht_pkg::STAT_FULL;
                done                      = 1'b1;
              end
            end
            orht_pkg::REQ_REMOVE: begin
              if (slot_used && match.id_eq) used_nxt[cmp_idx_r] = 1'b0;
              done = last;
            end
            orht_pkg::REQ_CLEAR: begin
              if (slot_used && match.owner_eq) used_nxt[cmp_idx_r] = 1'b0;
              done = last;
            end
            orht_pkg::REQ_FIND_ID, orht_pkg::REQ_FIND_PT: begin
              if (slot_used && ((req_r.kind == orht_pkg::REQ_FIND_ID) ? match.id_eq
                                                                       : match.pt_in)) begin
                res_nxt.found = 1'b1;
                res_nxt.index = orht_pkg::OUT_IDX_W'(cmp_idx_r);
                res_nxt.ent   = rd_ent;
                done          = 1'b1;
              end else begin
                done = last;
              end
            end
            default: done = 1'b1;
          endcase
          if (done) begin
            state_nxt   = orht_pkg::S_PUSH;
            cmp_vld_nxt = 1'b0;
          end
        end
      end
      orht_pkg::S_PUSH: begin
        if (out_free) state_nxt = orht_pkg::S_IDLE;
      end
      default: state_nxt = orht_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    if (push_fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= orht_pkg::S_IDLE;
      used_r      <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    res_r     <= res_nxt;
    rd_idx_r  <= rd_idx_nxt;
    cmp_idx_r <= rd_idx_r[orht_pkg::IDX_W-1:0];
    if (push_fire) begin
      out_r <= res_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_r.status;
  assign out_found       = out_r.found;
  assign out_entry_index = out_r.index;
  assign out_found_id    = out_r.ent.id;
  assign out_found_x     = out_r.ent.x;
  assign out_found_y     = out_r.ent.y;
  assign out_found_w     = out_r.ent.w;
  assign out_found_h     = out_r.ent.h;

  `ORHT_ASSERT(a_cmp_in_scan, clk, rst_n, cmp_vld_r |-> state_r == orht_pkg::S_SCAN, "compare outside scan")
  `ORHT_ASSERT(a_store_marks, clk, rst_n, store_fire |=> used_r[$past(cmp_idx_r)], "stored slot not marked used")
  `ORHT_ASSERT(a_scan_ends, clk, rst_n, (cmp_vld_r && cmp_idx_r == LAST_IDX) |=> state_r == orht_pkg::S_PUSH, "scan ran past last slot")
  `ORHT_ASSERT(a_out_from_push, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == orht_pkg::S_PUSH), "result without push")

endmodule

FILE: test/owned_rectangle_hit_table_tb.sv
module owned_rectangle_hit_table_tb;
  import orht_pkg::*;

  localparam int HOLD_CYCLES = 700;
  localparam int QUIET_LIMIT = 5000;
  localparam int TAIL_CYCLES = TABLE_ENTRIES + 40;
  localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

  typedef struct {
    logic [2:0]  kind;
    logic [7:0]  owner;
    logic [15:0] rx;
    logic [15:0] ry;
    logic [15:0] rw;
    logic [15:0] rh;
    logic [31:0] bid;
    logic [15:0] px;
    logic [15:0] py;
  } table_req_t;

  typedef struct packed {
    status_t     status;
    logic        found;
    logic [7:0]  index;
    logic [31:0] id;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] w;
    logic [15:0] h;
  } table_reply_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_req_type;
  logic [7:0]  in_owner;
  logic signed [15:0] in_rect_x;
  logic signed [15:0] in_rect_y;
  logic [15:0] in_rect_w;
  logic [15:0] in_rect_h;
  logic [31:0] in_button_id;
  logic signed [15:0] in_point_x;
  logic signed [15:0] in_point_y;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic        out_found;
  logic [7:0]  out_entry_index;
  logic [31:0] out_found_id;
  logic signed [15:0] out_found_x;
  logic signed [15:0] out_found_y;
  logic [15:0] out_found_w;
  logic [15:0] out_found_h;

  // shadow of the rectangle table
  logic         slot_busy [TABLE_ENTRIES];
  entry_t       slot_rect [TABLE_ENTRIES];
  table_reply_t table_replies_due [$];
  logic [7:0]   owner_pool [4];

  logic tx_idle_en = 1'b1;
  logic rx_idle_en = 1'b1;
  int   holds_asked = 0;
  int   holds_given = 0;
  int   quiet_cycles = 0;
  int   mismatches = 0;
  int   words_sent = 0;
  int   replies_seen = 0;
  int   stored = 0;
  int   dup_hits = 0;
  int   full_drops = 0;
  int   lookups_hit = 0;

  owned_rectangle_hit_table u_top (.*);

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 16);
    return $urandom_range(40, 150);
  endfunction

  function automatic table_reply_t found_reply(int i);
    table_reply_t rep;
    rep = '0;
    rep.found = 1'b1;
    rep.index = 8'(i);
    rep.id = slot_rect[i].id;
    rep.x = slot_rect[i].x;
    rep.y = slot_rect[i].y;
    rep.w = slot_rect[i].w;
    rep.h = slot_rect[i].h;
    lookups_hit++;
    return rep;
  endfunction

  function automatic table_reply_t apply_table_request(table_req_t r);
    table_reply_t rep;
    int qx, qy, lx, ly;
    rep = '0;
    qx = int'($signed(r.px)) - 1;
    qy = int'($signed(r.py)) - 1;
    case (r.kind)
      REQ_DEFINE: begin
        rep.status = STAT_FULL;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (!slot_busy[i]) begin
            slot_busy[i] = 1'b1;
            slot_rect[i] = '{owner: r.owner, x: r.rx, y: r.ry, w: r.rw, h: r.rh, id: r.bid};
            rep.status = STAT_DONE;
            rep.index = 8'(i);
            stored++;
            break;
          end
          if (slot_rect[i].owner == r.owner && slot_rect[i].x == r.rx &&
              slot_rect[i].y == r.ry && slot_rect[i].w == r.rw && slot_rect[i].h == r.rh) begin
            rep.status = STAT_DUP;
            rep.index = 8'(i);
            dup_hits++;
            break;
          end
        end
        if (rep.status == STAT_FULL) full_drops++;
      end
      REQ_REMOVE: begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
          if (slot_busy[i] && slot_rect[i].owner == r.owner &&
              (slot_rect[i].id & ID_CMP_MASK) == (r.bid & ID_CMP_MASK))
            slot_busy[i] = 1'b0;
      end
      REQ_FIND_ID: begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
          if (slot_busy[i] && slot_rect[i].owner == r.owner &&
              (slot_rect[i].id & ID_CMP_MASK) == (r.bid & ID_CMP_MASK)) begin
            rep = found_reply(i);
            break;
          end
      end
      REQ_FIND_PT: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (!slot_busy[i] || slot_rect[i].owner != r.owner) continue;
          lx = int'($signed(slot_rect[i].x));
          ly = int'($signed(slot_rect[i].y));
          if (qx > lx && qy > ly && qx <= lx + int'(slot_rect[i].w) &&
              qy <= ly + int'(slot_rect[i].h)) begin
            rep = found_reply(i);
            break;
          end
        end
      end
      REQ_CLEAR: begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
          if (slot_busy[i] && slot_rect[i].owner == r.owner) slot_busy[i] = 1'b0;
      end
      default: begin
      end
    endcase
    return rep;
  endfunction

  function automatic int pick_busy_slot();
    int busy [$];
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (slot_busy[i]) busy.push_back(i);
    if (busy.size() == 0) return -1;
    return busy[$urandom_range(0, busy.size() - 1)];
  endfunction

  function automatic int busy_count();
    int n;
    n = 0;
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (slot_busy[i]) n++;
    return n;
  endfunction

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      4, 5: return 16'($urandom_range(0, 400)) - 16'd200;
      default: return 16'($urandom);
    endcase
  endfunction

  // point near or inside one axis of a rectangle, boundaries favored
  function automatic logic [15:0] axis_point(logic [15:0] base, logic [15:0] span);
    int b, n, v;
    b = int'($signed(base));
    n = int'(span);
    case ($urandom_range(0, 5))
      0: v = b + 1;
      1: v = b + 2;
      2: v = b + n + 1;
      3: v = b + n + 2;
      default: v = b + 2 + ((n > 0) ? int'($urandom_range(0, n - 1)) : 0);
    endcase
    return 16'(v);
  endfunction

  function automatic table_req_t mk_req(logic [2:0] kind, logic [7:0] owner, int rx, int ry,
                                        int rw, int rh, logic [31:0] bid, int px, int py);
    table_req_t r;
    r.kind = kind;
    r.owner = owner;
    r.rx = 16'(rx);
    r.ry = 16'(ry);
    r.rw = 16'(rw);
    r.rh = 16'(rh);
    r.bid = bid;
    r.px = 16'(px);
    r.py = 16'(py);
    return r;
  endfunction

  function automatic table_req_t random_request();
    table_req_t r;
    entry_t e;
    int s, sel;
    r.kind = REQ_DEFINE;
    r.owner = owner_pool[$urandom_range(0, 3)];
    r.rx = rand_coord();
    r.ry = rand_coord();
    r.rw = rand_coord();
    r.rh = rand_coord();
    r.bid = $urandom;
    r.px = rand_coord();
    r.py = rand_coord();
    e = '0;
    s = pick_busy_slot();
    if (s >= 0) e = slot_rect[s];
    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      r.kind = REQ_DEFINE;
    end else if (sel < 36) begin
      r.kind = REQ_DEFINE;
      if (s >= 0) begin
        r.owner = e.owner;
        r.rx = e.x;
        r.ry = e.y;
        r.rw = e.w;
        r.rh = e.h;
      end
    end else if (sel < 46) begin
      r.kind = REQ_REMOVE;
      if (s >= 0 && $urandom_range(0, 3) != 0) begin
        r.owner = e.owner;
        r.bid = {8'($urandom), e.id[23:0]};
      end
    end else if (sel < 66) begin
      r.kind = REQ_FIND_ID;
      if (s >= 0 && $urandom_range(0, 3) != 0) begin
        r.owner = e.owner;
        r.bid = $urandom_range(0, 1) ? e.id : {8'($urandom), e.id[23:0]};
      end
    end else if (sel < 88) begin
      r.kind = REQ_FIND_PT;
      if (s >= 0 && $urandom_range(0, 4) != 0) begin
        r.owner = e.owner;
        r.px = axis_point(e.x, e.w);
        r.py = axis_point(e.y, e.h);
      end
    end else if (sel < 91) begin
      r.kind = REQ_CLEAR;
      if (s >= 0 && $urandom_range(0, 1) != 0) r.owner = e.owner;
    end else if (sel < 94) begin
      r.kind = 3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
    end else begin
      r.kind = 3'($urandom_range(0, 7));
      r.owner = 8'($urandom);
    end
    return r;
  endfunction

  task automatic send_word(input table_req_t r);
    int gap;
    in_valid <= 1'b1;
    in_req_type <= r.kind;
    in_owner <= r.owner;
    in_rect_x <= r.rx;
    in_rect_y <= r.ry;
    in_rect_w <= r.rw;
    in_rect_h <= r.rh;
    in_button_id <= r.bid;
    in_point_x <= r.px;
    in_point_y <= r.py;
    do @(posedge clk); while (in_stall);
    table_replies_due.push_back(apply_table_request(r));
    words_sent++;
    gap = tx_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_replies();
    in_valid <= 1'b0;
    do @(posedge clk); while (table_replies_due.size() != 0);
  endtask

  task automatic note_mismatch(string field, logic [31:0] want, logic [31:0] seen);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s of result word %0d: expected %h, got %h",
               field, replies_seen, want, seen);
  endtask

  task automatic test_directed_cases();
    logic [7:0] own_a, own_b, own_c;
    own_a = 8'hA5;
    own_b = 8'h5A;
    own_c = 8'h03;
    send_word(mk_req(REQ_DEFINE, own_a, -32768, -32768, 65535, 65535, 32'hFFFF_FFFF, 0, 0));
    send_word(mk_req(REQ_DEFINE, own_a, -32768, -32768, 65535, 65535, 32'h1234_5678, 0, 0));
    send_word(mk_req(REQ_DEFINE, own_b, -32768, -32768, 65535, 65535, 32'h00AB_CDEF, 0, 0));
    send_word(mk_req(REQ_DEFINE, own_a, 32767, 32767, 0, 0, 32'h8000_0001, 0, 0));
    send_word(mk_req(REQ_DEFINE, own_c, 100, -50, 10, 1, 32'h0000_0042, 0, 0));
    send_word(mk_req(REQ_FIND_ID, own_a, 0, 0, 0, 0, 32'h00FF_FFFF, 0, 0));
    send_word(mk_req(REQ_FIND_ID, own_a, 0, 0, 0, 0, 32'h7F00_0001, 0, 0));
    send_word(mk_req(REQ_FIND_ID, own_b, 0, 0, 0, 0, 32'h00AB_CDEE, 0, 0));
    send_word(mk_req(REQ_FIND_PT, own_a, 0, 0, 0, 0, 0, -32768, -32768));
    send_word(mk_req(REQ_FIND_PT, own_a, 0, 0, 0, 0, 0, -32766, -32766));
    send_word(mk_req(REQ_FIND_PT, own_a, 0, 0, 0, 0, 0, -32767, 0));
    send_word(mk_req(REQ_FIND_PT, own_b, 0, 0, 0, 0, 0, 32767, 32767));
    send_word(mk_req(REQ_FIND_PT, own_c, 0, 0, 0, 0, 0, 111, -48));
    send_word(mk_req(REQ_FIND_PT, own_c, 0, 0, 0, 0, 0, 112, -48));
    send_word(mk_req(REQ_FIND_PT, own_c, 0, 0, 0, 0, 0, 102, -48));
    send_word(mk_req(REQ_FIND_PT, own_c, 0, 0, 0, 0, 0, 101, -47));
    for (int k = REQ_UNUSED_LO; k <= REQ_UNUSED_HI; k++)
      send_word(mk_req(3'(k), own_a, -1, -1, 65535, 65535, $urandom, -1, -1));
    send_word(mk_req(REQ_REMOVE, own_a, 0, 0, 0, 0, 32'h01FF_FFFF, 0, 0));
    send_word(mk_req(REQ_FIND_ID, own_a, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, 0));
    send_word(mk_req(REQ_DEFINE, own_a, 0, 0, 0, 0, 32'h0000_0000, 0, 0));
    send_word(mk_req(REQ_CLEAR, own_a, 0, 0, 0, 0, 0, 0, 0));
    send_word(mk_req(REQ_FIND_PT, own_b, 0, 0, 0, 0, 0, 0, 0));
    send_word(mk_req(REQ_CLEAR, own_b, 0, 0, 0, 0, 0, 0, 0));
    send_word(mk_req(REQ_CLEAR, own_c, 0, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_random_traffic(int count, logic idle);
    foreach (owner_pool[k]) owner_pool[k] = 8'($urandom);
    tx_idle_en = idle;
    rx_idle_en = idle;
    repeat (count) send_word(random_request());
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  task automatic test_table_full();
    table_req_t r;
    int s;
    foreach (owner_pool[k]) owner_pool[k] = 8'($urandom);
    while (busy_count() < TABLE_ENTRIES) begin
      r = random_request();
      r.kind = REQ_DEFINE;
      send_word(r);
    end
    repeat (4) begin
      r = random_request();
      r.kind = REQ_DEFINE;
      send_word(r);
    end
    s = pick_busy_slot();
    r = mk_req(REQ_DEFINE, slot_rect[s].owner, slot_rect[s].x, slot_rect[s].y,
               slot_rect[s].w, slot_rect[s].h, $urandom, 0, 0);
    send_word(r);
    repeat (6) send_word(random_request());
    s = pick_busy_slot();
    while (s >= 0) begin
      send_word(mk_req(REQ_CLEAR, slot_rect[s].owner, 0, 0, 0, 0, $urandom, 0, 0));
      s = pick_busy_slot();
    end
  endtask

  task automatic test_result_backpressure();
    tx_idle_en = 1'b0;
    holds_asked++;
    repeat (12) send_word(random_request());
    tx_idle_en = 1'b1;
  endtask

  initial begin : result_stall_ctl
    int stall_left;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_given != holds_asked) begin
        out_stall <= 1'b1;
        for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
        holds_given++;
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        stall_left = rx_idle_en ? pick_gap() : 0;
      end
    end
  end

  always @(posedge clk) begin : reply_check
    table_reply_t due;
    if (rst_n && out_valid && !out_stall) begin
      replies_seen++;
      if (table_replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result word %0d arrived with nothing outstanding", replies_seen);
      end else begin
        due = table_replies_due.pop_front();
        if (out_status != due.status) note_mismatch("status", due.status, out_status);
        if (out_found != due.found) note_mismatch("found", due.found, out_found);
        if (out_entry_index != due.index)
          note_mismatch("entry_index", due.index, out_entry_index);
        if (out_found_id != due.id) note_mismatch("found_id", due.id, out_found_id);
        if (out_found_x != due.x) note_mismatch("found_x", due.x, out_found_x);
        if (out_found_y != due.y) note_mismatch("found_y", due.y, out_found_y);
        if (out_found_w != due.w) note_mismatch("found_w", due.w, out_found_w);
        if (out_found_h != due.h) note_mismatch("found_h", due.h, out_found_h);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no word moved for %0d cycles, %0d results outstanding",
               quiet_cycles, table_replies_due.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    foreach (slot_busy[i]) slot_busy[i] = 1'b0;
    foreach (owner_pool[k]) owner_pool[k] = 8'($urandom);
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_req_type <= REQ_DEFINE;
    in_owner <= '0;
    in_rect_x <= '0;
    in_rect_y <= '0;
    in_rect_w <= '0;
    in_rect_h <= '0;
    in_button_id <= '0;
    in_point_x <= '0;
    in_point_y <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    wait_for_replies();
    test_random_traffic(540, 1'b1);
    wait_for_replies();
    test_result_backpressure();
    wait_for_replies();
    test_random_traffic(150, 1'b0);
    wait_for_replies();
    test_table_full();
    wait_for_replies();
    test_random_traffic(450, 1'b1);
    wait_for_replies();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d requests sent: %0d rectangles stored, %0d duplicates, %0d full-table drops",
             words_sent, stored, dup_hits, full_drops);
    $display("%0d lookups hit, %0d result words checked, %0d mismatches",
             lookups_hit, replies_seen, mismatches);
    if (mismatches == 0 && table_replies_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
